>>> design/mue_pkg.sv
// Shared types and constants of the mesh unused-entry counter.
`timescale 1ns / 1ps
`default_nettype none
package mue_pkg;

    localparam int IDX_W      = 12;
    localparam int MAT_IDX_W  = 8;
    localparam int VCNT_W     = 13;
    localparam int MCNT_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CORNERS    = 3;
    localparam int STEP_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATERIAL_COUNT = 2'd2;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORNERS - 1);

    // effective counts, already saturated to capacity
    typedef struct packed {
        logic [VCNT_W-1:0] vertex;
        logic [VCNT_W-1:0] normal;
        logic [MCNT_W-1:0] material;
    } t_limits;

    // one classified face request
    typedef struct packed {
        logic [CORNERS-1:0]            vtx_ok;
        logic [CORNERS-1:0][IDX_W-1:0] vtx_idx;
        logic [CORNERS-1:0]            nrm_ok;
        logic [CORNERS-1:0][IDX_W-1:0] nrm_idx;
        logic                          mat_ok;
        logic [MAT_IDX_W-1:0]          mat_idx;
        logic                          last;
        logic                          bad;
    } t_cmd;

endpackage
`default_nettype wire

>>> design/mue_front.sv
// Front end: count registers, saturation and range classification of each request.
`timescale 1ns / 1ps
`default_nettype none
module mue_front import mue_pkg::*; #(
    parameter int unsigned MAX_VERTICES  = 4096,
    parameter int unsigned MAX_NORMALS   = 4096,
    parameter int unsigned MAX_MATERIALS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_push,
    input  wire logic                  i_has_face,
    input  wire logic [IDX_W-1:0]      i_vertex_a,
    input  wire logic [IDX_W-1:0]      i_vertex_b,
    input  wire logic [IDX_W-1:0]      i_vertex_c,
    input  wire logic [IDX_W-1:0]      i_normal_a,
    input  wire logic [IDX_W-1:0]      i_normal_b,
    input  wire logic [IDX_W-1:0]      i_normal_c,
    input  wire logic [MAT_IDX_W-1:0]  i_material_index,
    input  wire logic                  i_last_face,
    input  wire logic                  i_clear_busy,
    input  wire logic                  i_q_full,
    output logic                       o_full,
    output logic                       o_q_push,
    output t_cmd                       o_q_cmd,
    output t_limits                    o_limits
);

    logic [VCNT_W-1:0] r_vertex_count;
    logic [VCNT_W-1:0] r_normal_count;
    logic [MCNT_W-1:0] r_material_count;

    logic [CORNERS-1:0][IDX_W-1:0] w_vtx;
    logic [CORNERS-1:0][IDX_W-1:0] w_nrm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count   <= '0;
            r_normal_count   <= '0;
            r_material_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VERTEX_COUNT:   r_vertex_count   <= i_cfg_data[VCNT_W-1:0];
                REG_NORMAL_COUNT:   r_normal_count   <= i_cfg_data[VCNT_W-1:0];
                REG_MATERIAL_COUNT: r_material_count <= i_cfg_data[MCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate to capacity
    assign o_limits.vertex   = (32'(r_vertex_count) < MAX_VERTICES) ?
                               r_vertex_count : VCNT_W'(MAX_VERTICES);
    assign o_limits.normal   = (32'(r_normal_count) < MAX_NORMALS) ?
                               r_normal_count : VCNT_W'(MAX_NORMALS);
    assign o_limits.material = (32'(r_material_count) < MAX_MATERIALS) ?
                               r_material_count : MCNT_W'(MAX_MATERIALS);

    assign w_vtx = {i_vertex_c, i_vertex_b, i_vertex_a};
    assign w_nrm = {i_normal_c, i_normal_b, i_normal_a};

    always_comb begin
        for (int k = 0; k < CORNERS; k++) begin
            o_q_cmd.vtx_ok[k]  = i_has_face && ({1'b0, w_vtx[k]} < o_limits.vertex);
            o_q_cmd.nrm_ok[k]  = i_has_face && ({1'b0, w_nrm[k]} < o_limits.normal);
            o_q_cmd.vtx_idx[k] = w_vtx[k];
            o_q_cmd.nrm_idx[k] = w_nrm[k];
        end
        o_q_cmd.mat_ok  = i_has_face && ({1'b0, i_material_index} < o_limits.material);
        o_q_cmd.mat_idx = i_material_index;
        o_q_cmd.last    = i_last_face;
        o_q_cmd.bad     = i_has_face &&
                          !((&o_q_cmd.vtx_ok) && (&o_q_cmd.nrm_ok) && o_q_cmd.mat_ok);
    end

    assign o_full   = i_q_full || i_clear_busy;
    assign o_q_push = i_push && !o_full;

endmodule
`default_nettype wire

>>> design/mue_cmdq.sv
// Two-entry request queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module mue_cmdq import mue_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    localparam int DEPTH = 2;
    localparam int PW    = 1;

    t_cmd          r_entry [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/mue_back.sv
// Back end: bitmap memories, marking sequencer, counting scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module mue_back import mue_pkg::*; #(
    parameter int unsigned MAX_VERTICES  = 4096,
    parameter int unsigned MAX_NORMALS   = 4096,
    parameter int unsigned MAX_MATERIALS = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_limits    i_limits,
    input  wire logic       i_q_valid,
    input  wire t_cmd       i_q_cmd,
    output logic            o_q_pop,
    output logic            o_clear_busy,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [VCNT_W-1:0] o_unused_vertices,
    output logic [VCNT_W-1:0] o_unused_normals,
    output logic [MCNT_W-1:0] o_unused_materials,
    output logic            o_bad_index
);

    localparam int VAW = (MAX_VERTICES > 1)  ? $clog2(MAX_VERTICES)  : 1;
    localparam int NAW = (MAX_NORMALS > 1)   ? $clog2(MAX_NORMALS)   : 1;
    localparam int MAW = (MAX_MATERIALS > 1) ? $clog2(MAX_MATERIALS) : 1;
    localparam int unsigned SCAN_VN = (MAX_VERTICES > MAX_NORMALS) ? MAX_VERTICES : MAX_NORMALS;
    localparam int unsigned SCAN_DEPTH = (SCAN_VN > MAX_MATERIALS) ? SCAN_VN : MAX_MATERIALS;
    localparam int SW = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
    localparam logic [SW-1:0] SCAN_LAST = SW'(SCAN_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [SW-1:0]     r_addr;
    t_cmd              r_cmd;
    logic              r_err;
    logic              r_out_valid;
    logic [VCNT_W-1:0] r_unused_v;
    logic [VCNT_W-1:0] r_unused_n;
    logic [MCNT_W-1:0] r_unused_m;
    logic              r_cnt_v;
    logic              r_cnt_n;
    logic              r_cnt_m;

    logic r_vtx_mem [MAX_VERTICES];
    logic r_nrm_mem [MAX_NORMALS];
    logic r_mat_mem [MAX_MATERIALS];
    logic r_v_rd;
    logic r_n_rd;
    logic r_m_rd;

    logic           w_v_we, w_n_we, w_m_we;
    logic           w_v_re, w_n_re, w_m_re;
    logic [VAW-1:0] w_v_addr;
    logic [NAW-1:0] w_n_addr;
    logic [MAW-1:0] w_m_addr;
    logic           w_wdata;
    logic           w_v_act, w_n_act, w_m_act;
    logic           w_take;

    assign w_v_act = 32'(r_addr) < MAX_VERTICES;
    assign w_n_act = 32'(r_addr) < MAX_NORMALS;
    assign w_m_act = 32'(r_addr) < MAX_MATERIALS;

    assign w_take = i_q_valid && ((r_state == S_IDLE) ||
                    (r_state == S_MARK && r_step == STEP_LAST && !r_cmd.last));
    assign o_q_pop      = w_take;
    assign o_clear_busy = (r_state == S_CLEAR);
    assign o_empty      = !r_out_valid;

    always_comb begin
        w_v_we   = 1'b0;
        w_n_we   = 1'b0;
        w_m_we   = 1'b0;
        w_v_re   = 1'b0;
        w_n_re   = 1'b0;
        w_m_re   = 1'b0;
        w_wdata  = 1'b0;
        w_v_addr = r_addr[VAW-1:0];
        w_n_addr = r_addr[NAW-1:0];
        w_m_addr = r_addr[MAW-1:0];
        case (r_state)
            S_MARK: begin
                w_wdata  = 1'b1;
                w_v_we   = r_cmd.vtx_ok[r_step];
                w_n_we   = r_cmd.nrm_ok[r_step];
                w_m_we   = r_cmd.mat_ok && (r_step == '0);
                w_v_addr = VAW'(r_cmd.vtx_idx[r_step]);
                w_n_addr = NAW'(r_cmd.nrm_idx[r_step]);
                w_m_addr = MAW'(r_cmd.mat_idx);
            end
            S_CLEAR, S_SCAN: begin
                // read old mark and clear it in the same cycle
                w_v_we = w_v_act;
                w_n_we = w_n_act;
                w_m_we = w_m_act;
                w_v_re = w_v_act;
                w_n_re = w_n_act;
                w_m_re = w_m_act;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_v_we) begin
            r_vtx_mem[w_v_addr] <= w_wdata;
        end
        if (w_v_re) begin
            r_v_rd <= r_vtx_mem[w_v_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_n_we) begin
            r_nrm_mem[w_n_addr] <= w_wdata;
        end
        if (w_n_re) begin
            r_n_rd <= r_nrm_mem[w_n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_we) begin
            r_mat_mem[w_m_addr] <= w_wdata;
        end
        if (w_m_re) begin
            r_m_rd <= r_mat_mem[w_m_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= '0;
            r_addr      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_unused_v  <= '0;
            r_unused_n  <= '0;
            r_unused_m  <= '0;
            r_cnt_v     <= 1'b0;
            r_cnt_n     <= 1'b0;
            r_cnt_m     <= 1'b0;
        end else begin
            r_cnt_v <= (r_state == S_SCAN) && (32'(r_addr) < 32'(i_limits.vertex));
            r_cnt_n <= (r_state == S_SCAN) && (32'(r_addr) < 32'(i_limits.normal));
            r_cnt_m <= (r_state == S_SCAN) && (32'(r_addr) < 32'(i_limits.material));
            if (r_cnt_v && !r_v_rd) begin
                r_unused_v <= r_unused_v + 1'b1;
            end
            if (r_cnt_n && !r_n_rd) begin
                r_unused_n <= r_unused_n + 1'b1;
            end
            if (r_cnt_m && !r_m_rd) begin
                r_unused_m <= r_unused_m + 1'b1;
            end
            // in S_RESULT a pop is handled together with the reload below
            if (i_pop && r_out_valid && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                r_cmd <= i_q_cmd;
                r_err <= r_err || i_q_cmd.bad;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == SCAN_LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_take) begin
                        r_step  <= '0;
                        r_state <= S_MARK;
                    end
                end
                S_MARK: begin
                    if (r_step == STEP_LAST) begin
                        r_step <= '0;
                        if (r_cmd.last) begin
                            r_state <= S_SCAN;
                        end else if (!w_take) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_addr == SCAN_LAST) begin
                        r_addr  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || i_pop) begin
                        r_out_valid        <= 1'b1;
                        o_unused_vertices  <= r_unused_v;
                        o_unused_normals   <= r_unused_n;
                        o_unused_materials <= r_unused_m;
                        o_bad_index        <= r_err;
                        r_unused_v         <= '0;
                        r_unused_n         <= '0;
                        r_unused_m         <= '0;
                        r_err              <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_MARK) |->
        (r_unused_v == '0 && r_unused_n == '0 && r_unused_m == '0))
        else $error("unused counters not clean before scan");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |->
        (r_unused_v <= i_limits.vertex && r_unused_n <= i_limits.normal &&
         r_unused_m <= i_limits.material))
        else $error("unused count exceeds effective count");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !w_take)
        else $error("request taken during clearing pass");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_out_valid && !i_pop) |=> (r_state == S_RESULT))
        else $error("result register overwritten");

endmodule
`default_nettype wire

>>> design/mesh_unused_entry_counter.sv
// Top level of the mesh unused-entry counter.
// Faces enter through a push/full queue port and are range-checked against the
// saturated vertex, normal and material counts, then queued (two deep) for the
// marking sequencer. Each request steps through the sequencer one face corner at
// a time, bounded by the single write port of each bitmap memory. A request
// flagged last adds a counting scan over max(MAX_VERTICES, MAX_NORMALS,
// MAX_MATERIALS) addresses, which also clears the bitmaps, before its result
// lands in the output register (empty/pop). After reset a clearing pass over
// max(MAX_VERTICES, MAX_NORMALS, MAX_MATERIALS) addresses runs with full held
// high; count writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module mesh_unused_entry_counter import mue_pkg::*; #(
    parameter int unsigned MAX_VERTICES  = 4096,
    parameter int unsigned MAX_NORMALS   = 4096,
    parameter int unsigned MAX_MATERIALS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_has_face,
    input  wire logic [IDX_W-1:0]      i_vertex_a,
    input  wire logic [IDX_W-1:0]      i_vertex_b,
    input  wire logic [IDX_W-1:0]      i_vertex_c,
    input  wire logic [IDX_W-1:0]      i_normal_a,
    input  wire logic [IDX_W-1:0]      i_normal_b,
    input  wire logic [IDX_W-1:0]      i_normal_c,
    input  wire logic [MAT_IDX_W-1:0]  i_material_index,
    input  wire logic                  i_last_face,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [VCNT_W-1:0]          o_unused_vertices,
    output logic [VCNT_W-1:0]          o_unused_normals,
    output logic [MCNT_W-1:0]          o_unused_materials,
    output logic                       o_bad_index
);

    t_limits w_limits;
    t_cmd    w_push_cmd;
    t_cmd    w_head_cmd;
    logic    w_q_push;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_q_pop;
    logic    w_clear_busy;

    mue_front #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_NORMALS   (MAX_NORMALS),
        .MAX_MATERIALS (MAX_MATERIALS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_push           (push),
        .i_has_face       (i_has_face),
        .i_vertex_a       (i_vertex_a),
        .i_vertex_b       (i_vertex_b),
        .i_vertex_c       (i_vertex_c),
        .i_normal_a       (i_normal_a),
        .i_normal_b       (i_normal_b),
        .i_normal_c       (i_normal_c),
        .i_material_index (i_material_index),
        .i_last_face      (i_last_face),
        .i_clear_busy     (w_clear_busy),
        .i_q_full         (w_q_full),
        .o_full           (full),
        .o_q_push         (w_q_push),
        .o_q_cmd          (w_push_cmd),
        .o_limits         (w_limits)
    );

    mue_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd),
        .i_pop   (w_q_pop)
    );

    mue_back #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_NORMALS   (MAX_NORMALS),
        .MAX_MATERIALS (MAX_MATERIALS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_limits           (w_limits),
        .i_q_valid          (w_q_valid),
        .i_q_cmd            (w_head_cmd),
        .o_q_pop            (w_q_pop),
        .o_clear_busy       (w_clear_busy),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_unused_vertices  (o_unused_vertices),
        .o_unused_normals   (o_unused_normals),
        .o_unused_materials (o_unused_materials),
        .o_bad_index        (o_bad_index)
    );

endmodule
`default_nettype wire

>>> verif/tb_mesh_unused_entry_counter.sv
// Self-checking testbench for the mesh unused-entry counter.
`timescale 1ns / 1ps
module tb_mesh_unused_entry_counter;
    import mue_pkg::*;

    localparam int VTX_CAP       = 4096;
    localparam int NRM_CAP       = 4096;
    localparam int MAT_CAP       = 256;
    localparam int ITEM_TARGET   = 1900;
    localparam int MESHES_PER_PH = 6;
    localparam int HOLD_CYCLES   = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 4200;
    localparam int TIMEOUT_NS    = 400_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic                 has_face;
        logic [IDX_W-1:0]     vertex_a;
        logic [IDX_W-1:0]     vertex_b;
        logic [IDX_W-1:0]     vertex_c;
        logic [IDX_W-1:0]     normal_a;
        logic [IDX_W-1:0]     normal_b;
        logic [IDX_W-1:0]     normal_c;
        logic [MAT_IDX_W-1:0] material_index;
        logic                 last_face;
    } t_face;

    typedef struct packed {
        logic [VCNT_W-1:0] verts;
        logic [VCNT_W-1:0] norms;
        logic [MCNT_W-1:0] mats;
        logic              bad;
    } t_tally;

    typedef enum logic {ROW_FACE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_face                 face;
        bit                    typed;
        t_tally                want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    logic                  pop        = 1'b0;
    t_face                 face_drv   = '0;
    logic                  full;
    logic                  empty;
    logic [VCNT_W-1:0]     o_unused_vertices;
    logic [VCNT_W-1:0]     o_unused_normals;
    logic [MCNT_W-1:0]     o_unused_materials;
    logic                  o_bad_index;

    // predictor state
    int cnt_vtx = 0;
    int cnt_nrm = 0;
    int cnt_mat = 0;
    bit vtx_seen [VTX_CAP];
    bit nrm_seen [NRM_CAP];
    bit mat_seen [MAT_CAP];
    bit idx_fault = 1'b0;

    t_tally tally_q [$];
    int     errors      = 0;
    int     items_sent  = 0;
    int     idle_pct    = 0;
    int     stall_pct   = 0;
    int     hold_asked  = 0;
    int     hold_taken  = 0;
    int     hold_left   = 0;

    mesh_unused_entry_counter #(
        .MAX_VERTICES  (VTX_CAP),
        .MAX_NORMALS   (NRM_CAP),
        .MAX_MATERIALS (MAT_CAP)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .push               (push),
        .full               (full),
        .i_has_face         (face_drv.has_face),
        .i_vertex_a         (face_drv.vertex_a),
        .i_vertex_b         (face_drv.vertex_b),
        .i_vertex_c         (face_drv.vertex_c),
        .i_normal_a         (face_drv.normal_a),
        .i_normal_b         (face_drv.normal_b),
        .i_normal_c         (face_drv.normal_c),
        .i_material_index   (face_drv.material_index),
        .i_last_face        (face_drv.last_face),
        .empty              (empty),
        .pop                (pop),
        .o_unused_vertices  (o_unused_vertices),
        .o_unused_normals   (o_unused_normals),
        .o_unused_materials (o_unused_materials),
        .o_bad_index        (o_bad_index)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int eff_of(int cnt, int cap);
        return (cnt < cap) ? cnt : cap;
    endfunction

    // marks one face; on the closing request returns 1 with the tally and clears the maps
    function automatic bit tally_face(input t_face f, output t_tally t);
        int ev, en, em, nv, nn, nm;
        logic [IDX_W-1:0] vi [CORNERS];
        logic [IDX_W-1:0] ni [CORNERS];
        ev = eff_of(cnt_vtx, VTX_CAP);
        en = eff_of(cnt_nrm, NRM_CAP);
        em = eff_of(cnt_mat, MAT_CAP);
        vi = '{f.vertex_a, f.vertex_b, f.vertex_c};
        ni = '{f.normal_a, f.normal_b, f.normal_c};
        nv = 0;
        nn = 0;
        nm = 0;
        t  = '0;
        if (f.has_face) begin
            foreach (vi[k]) begin
                if (vi[k] < ev) vtx_seen[vi[k]] = 1'b1;
                else idx_fault = 1'b1;
                if (ni[k] < en) nrm_seen[ni[k]] = 1'b1;
                else idx_fault = 1'b1;
            end
            if (f.material_index < em) mat_seen[f.material_index] = 1'b1;
            else idx_fault = 1'b1;
        end
        if (!f.last_face) return 1'b0;
        for (int k = 0; k < ev; k++) if (!vtx_seen[k]) nv++;
        for (int k = 0; k < en; k++) if (!nrm_seen[k]) nn++;
        for (int k = 0; k < em; k++) if (!mat_seen[k]) nm++;
        t.verts = VCNT_W'(nv);
        t.norms = VCNT_W'(nn);
        t.mats  = MCNT_W'(nm);
        t.bad   = idx_fault;
        vtx_seen  = '{default: 1'b0};
        nrm_seen  = '{default: 1'b0};
        mat_seen  = '{default: 1'b0};
        idx_fault = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_stim_row face_row(bit hf, int va, int vb, int vc, int na, int nb,
                                           int nc, int mat, bit lf, bit typed = 1'b0,
                                           int uv = 0, int un = 0, int um = 0,
                                           bit flag = 1'b0);
        t_stim_row r;
        r.kind    = ROW_FACE;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.face    = '{has_face: hf, vertex_a: IDX_W'(va), vertex_b: IDX_W'(vb),
                      vertex_c: IDX_W'(vc), normal_a: IDX_W'(na), normal_b: IDX_W'(nb),
                      normal_c: IDX_W'(nc), material_index: MAT_IDX_W'(mat), last_face: lf};
        r.typed   = typed;
        r.want    = '{verts: VCNT_W'(uv), norms: VCNT_W'(un), mats: MCNT_W'(um), bad: flag};
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
        t_stim_row r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = CFG_DATA_W'(val);
        r.face    = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic int pick_count(int cap, int few);
        int r;
        r = $urandom_range(99);
        if (r < 5) return 0;
        if (r < 15) return cap;
        if (r < 25) return $urandom_range(2 * cap - 1, cap + 1);
        if (r < 70) return $urandom_range(few, 1);
        return $urandom_range(cap - 1, 1);
    endfunction

    function automatic int pick_idx(int eff, int cap);
        if (eff != 0 && $urandom_range(99) < 95) return $urandom_range(eff - 1);
        return $urandom_range(cap - 1);
    endfunction

    function automatic t_face random_face(bit well);
        t_face f;
        int ev, en, em;
        ev = eff_of(cnt_vtx, VTX_CAP);
        en = eff_of(cnt_nrm, NRM_CAP);
        em = eff_of(cnt_mat, MAT_CAP);
        f  = '0;
        if (well) begin
            f.has_face       = ($urandom_range(19) != 0);
            f.vertex_a       = IDX_W'(pick_idx(ev, VTX_CAP));
            f.vertex_b       = IDX_W'(pick_idx(ev, VTX_CAP));
            f.vertex_c       = IDX_W'(pick_idx(ev, VTX_CAP));
            f.normal_a       = IDX_W'(pick_idx(en, NRM_CAP));
            f.normal_b       = IDX_W'(pick_idx(en, NRM_CAP));
            f.normal_c       = IDX_W'(pick_idx(en, NRM_CAP));
            f.material_index = MAT_IDX_W'(pick_idx(em, MAT_CAP));
        end else begin
            f.has_face       = 1'($urandom);
            f.vertex_a       = IDX_W'($urandom);
            f.vertex_b       = IDX_W'($urandom);
            f.vertex_c       = IDX_W'($urandom);
            f.normal_a       = IDX_W'($urandom);
            f.normal_b       = IDX_W'($urandom);
            f.normal_c       = IDX_W'($urandom);
            f.material_index = MAT_IDX_W'($urandom);
        end
        return f;
    endfunction

    // called just after a falling edge; returns just after a falling edge with push still high
    task automatic offer(input t_face f, input bit typed, input t_tally given);
        t_tally t;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push     <= 1'b1;
        face_drv <= f;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (tally_face(f, t)) tally_q.push_back(typed ? given : t);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (tally_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_VERTEX_COUNT:   cnt_vtx = int'(val);
            REG_NORMAL_COUNT:   cnt_nrm = int'(val);
            REG_MATERIAL_COUNT: cnt_mat = int'(val[MCNT_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // result side: random stalls plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_tally want;
        if (i_rst_n && pop && !empty) begin
            if (tally_q.size() == 0) begin
                $error("result with no request pending: %0d %0d %0d %0d", o_unused_vertices,
                       o_unused_normals, o_unused_materials, o_bad_index);
                errors++;
            end else begin
                want = tally_q.pop_front();
                if (o_unused_vertices !== want.verts) begin
                    $error("unused_vertices: expected %0d, got %0d", want.verts,
                           o_unused_vertices);
                    errors++;
                end
                if (o_unused_normals !== want.norms) begin
                    $error("unused_normals: expected %0d, got %0d", want.norms, o_unused_normals);
                    errors++;
                end
                if (o_unused_materials !== want.mats) begin
                    $error("unused_materials: expected %0d, got %0d", want.mats,
                           o_unused_materials);
                    errors++;
                end
                if (o_bad_index !== want.bad) begin
                    $error("bad_index: expected %0d, got %0d", want.bad, o_bad_index);
                    errors++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_stim_row tbl [$];
        t_face     f;
        int        idle_plan  [4];
        int        stall_plan [4];
        int        round, n_faces;
        bit        well;

        idle_plan  = '{0, 68, 0, 11};
        stall_plan = '{0, 0, 68, 11};

        // counts all zero after reset
        tbl.push_back(face_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        tbl.push_back(face_row(1, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1));
        tbl.push_back(cfg_row(REG_VERTEX_COUNT, 4096));
        tbl.push_back(cfg_row(REG_NORMAL_COUNT, 4096));
        tbl.push_back(cfg_row(REG_MATERIAL_COUNT, 256));
        tbl.push_back(face_row(0, 4095, 4095, 4095, 4095, 4095, 4095, 255, 1,
                               1, 4096, 4096, 256, 0));
        tbl.push_back(face_row(1, 4095, 4095, 4095, 4095, 4095, 4095, 255, 0));
        tbl.push_back(face_row(1, 0, 0, 0, 0, 0, 0, 0, 1, 1, 4094, 4094, 254, 0));
        // counts above capacity saturate
        tbl.push_back(cfg_row(REG_VERTEX_COUNT, 8191));
        tbl.push_back(cfg_row(REG_NORMAL_COUNT, 5000));
        tbl.push_back(cfg_row(REG_MATERIAL_COUNT, 511));
        tbl.push_back(face_row(1, 1, 2, 3, 4, 5, 6, 7, 1, 1, 4093, 4093, 255, 0));
        tbl.push_back(face_row(1, 'hAAA, 'h555, 'hFFF, 'h555, 'hAAA, 'h000, 'hAA, 0));
        tbl.push_back(face_row(1, 'h555, 'hAAA, 'h123, 'hAAA, 'h555, 'hFFF, 'h55, 1));
        // tiny mesh, plus a write to an unmapped register
        tbl.push_back(cfg_row(REG_VERTEX_COUNT, 3));
        tbl.push_back(cfg_row(REG_NORMAL_COUNT, 2));
        tbl.push_back(cfg_row(REG_MATERIAL_COUNT, 1));
        tbl.push_back(cfg_row(REG_NONE, 8191));
        tbl.push_back(face_row(1, 0, 1, 2, 0, 1, 1, 0, 0));
        tbl.push_back(face_row(1, 2, 1, 0, 1, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        tbl.push_back(face_row(1, 3, 0, 0, 0, 0, 2, 1, 1, 1, 2, 1, 1, 1));
        tbl.push_back(face_row(0, 4095, 4095, 4095, 4095, 4095, 4095, 255, 0));
        tbl.push_back(face_row(1, 0, 0, 0, 0, 0, 0, 0, 0));
        tbl.push_back(face_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 2, 1, 0, 0));
        // zero counts: every index is out of range
        tbl.push_back(cfg_row(REG_VERTEX_COUNT, 0));
        tbl.push_back(cfg_row(REG_NORMAL_COUNT, 0));
        tbl.push_back(cfg_row(REG_MATERIAL_COUNT, 0));
        tbl.push_back(face_row(1, 5, 6, 7, 8, 9, 10, 11, 0));
        tbl.push_back(face_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (tbl[r]) begin
            if (tbl[r].kind == ROW_CFG) begin
                settle();
                write_reg(tbl[r].reg_idx, tbl[r].reg_val);
            end else begin
                offer(tbl[r].face, tbl[r].typed, tbl[r].want);
            end
        end

        round = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            idle_pct  = idle_plan[round % 4];
            stall_pct = stall_plan[round % 4];
            write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(pick_count(VTX_CAP, 64)));
            write_reg(REG_NORMAL_COUNT, CFG_DATA_W'(pick_count(NRM_CAP, 64)));
            write_reg(REG_MATERIAL_COUNT,
                      CFG_DATA_W'(pick_count(MAT_CAP, 16) | ($urandom_range(15) << MCNT_W)));
            if (round == 0) begin
                // hold the result side off so the request queue backs up
                hold_asked++;
                repeat (8) begin
                    f = random_face(1'b1);
                    f.last_face = 1'b1;
                    offer(f, 1'b0, '0);
                end
            end
            repeat (MESHES_PER_PH) begin
                n_faces = ($urandom_range(9) == 0) ? $urandom_range(200, 60)
                                                   : $urandom_range(40, 1);
                well = ($urandom_range(99) < 85);
                for (int j = 0; j < n_faces; j++) begin
                    f = random_face(well);
                    f.last_face = (j == n_faces - 1) || (!well && $urandom_range(9) == 0);
                    offer(f, 1'b0, '0);
                end
            end
            round++;
        end

        push <= 1'b0;
        while (tally_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> mesh_unused_entry_counter.f
design/mue_pkg.sv
design/mue_front.sv
design/mue_cmdq.sv
design/mue_back.sv
design/mesh_unused_entry_counter.sv
verif/tb_mesh_unused_entry_counter.sv
